>>> src/mirs_pkg.sv
// Package for the message ID range set: sizes, range type, status and phase codes.
// No dependencies; every module of the block imports it.
`default_nettype none
package mirs_pkg;
    localparam int MAX_RANGES = 16;
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int MW = $clog2(MAX_RANGES + 2);
    localparam logic [7:0] GSM_NET = 8'd1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_INVALID = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
    } t_range;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_MERGE  = 2'd1,
        PH_AFTER  = 2'd2,
        PH_SPLIT  = 2'd3
    } t_phase;
endpackage
`default_nettype wire

>>> src/message_id_range_set.sv
// Top level of the message ID range set: sequencer, merge/split step, result register.
// Depends on mirs_pkg and mirs_cell.
//
//  channel  | valid   | ready   | payload
//  request  | i_valid | o_ready | i_opcode, i_from_id, i_to_id, i_net_type
//  result   | o_valid | i_ready | o_status, o_range_lo, o_range_hi, o_is_empty, o_last
//
// One request at a time. A count pass rotates the n stored ranges through the
// chain, then a build pass pops them again while the new table is written
// behind them and streamed out.
// Bad arguments give one result row from the report state; a full table gives
// it there once the count pass ends. An empty table adds one marker row.
// Reset empties the table; a stalled result holds the build pass.
`default_nettype none
module message_id_range_set (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire                   i_opcode,
    input  wire  [15:0]           i_from_id,
    input  wire  [15:0]           i_to_id,
    input  wire  [7:0]            i_net_type,
    output logic                  o_valid,
    input  wire                   i_ready,
    output mirs_pkg::t_status     o_status,
    output logic [15:0]           o_range_lo,
    output logic [15:0]           o_range_hi,
    output logic                  o_is_empty,
    output logic                  o_last
);
    import mirs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_COUNT  = 5'b00010,
        S_BUILD  = 5'b00100,
        S_REPORT = 5'b01000,
        S_EMPTY  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_op;
    logic [15:0]      r_a, r_b;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_rem, n_rem;
    logic [CW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_ecnt, n_ecnt;
    logic [MW-1:0]    r_m, n_m;
    t_phase           r_ph, n_ph;
    logic [15:0]      r_acc_lo, r_acc_hi, n_acc_lo, n_acc_hi;
    t_status          r_rep, n_rep;

    logic             r_o_valid;
    t_status          r_o_status;
    logic [15:0]      r_o_lo, r_o_hi;
    logic             r_o_empty, r_o_last;

    t_range           chain [MAX_RANGES];
    t_range           head;
    logic             head_v;

    // Step outputs
    logic             s_emit, s_cons, s_fin;
    t_range           s_rng;

    logic             out_free, step_en, ld;
    t_status          ld_status;
    t_range           ld_rng;
    logic             ld_empty, ld_last;
    logic             pop, push;
    t_range           push_data;
    logic [CW-1:0]    occ, widx;

    assign head   = chain[0];
    assign head_v = (r_rem != '0);
    assign out_free = !r_o_valid || i_ready;

    // Merge or split step on the head range
    always_comb begin
        s_emit   = 1'b0;
        s_cons   = 1'b0;
        s_fin    = 1'b0;
        s_rng    = head;
        n_ph     = r_ph;
        n_acc_lo = r_acc_lo;
        n_acc_hi = r_acc_hi;
        if (r_op) begin
            case (r_ph)
                PH_BEFORE: begin
                    if (head_v && (({1'b0, head.hi} + 17'd1) < {1'b0, r_a})) begin
                        s_emit = 1'b1;
                        s_cons = 1'b1;
                    end else begin
                        n_ph     = PH_MERGE;
                        n_acc_lo = r_a;
                        n_acc_hi = r_b;
                    end
                end
                PH_MERGE: begin
                    if (head_v && ({1'b0, head.lo} <= ({1'b0, r_b} + 17'd1))) begin
                        s_cons = 1'b1;
                        if (head.lo < r_acc_lo) n_acc_lo = head.lo;
                        if (head.hi > r_acc_hi) n_acc_hi = head.hi;
                    end else begin
                        s_emit   = 1'b1;
                        s_rng.lo = r_acc_lo;
                        s_rng.hi = r_acc_hi;
                        n_ph     = PH_AFTER;
                    end
                end
                default: begin
                    if (head_v) begin
                        s_emit = 1'b1;
                        s_cons = 1'b1;
                    end else begin
                        s_fin = 1'b1;
                    end
                end
            endcase
        end else begin
            if (!head_v) begin
                s_fin = 1'b1;
            end else if (head.hi < r_a || head.lo > r_b) begin
                s_emit = 1'b1;
                s_cons = 1'b1;
            end else if (r_ph == PH_SPLIT) begin
                s_emit   = 1'b1;
                s_cons   = 1'b1;
                s_rng.lo = r_b + 16'd1;
                n_ph     = PH_BEFORE;
            end else if (head.lo < r_a) begin
                s_emit   = 1'b1;
                s_rng.hi = r_a - 16'd1;
                if (head.hi > r_b) begin
                    n_ph = PH_SPLIT;
                end else begin
                    s_cons = 1'b1;
                end
            end else begin
                s_cons   = 1'b1;
                s_emit   = (head.hi > r_b);
                s_rng.lo = r_b + 16'd1;
            end
        end
    end

    // Chain control: rotate in the count pass, rebuild in the build pass
    assign step_en = (r_state == S_COUNT) || ((r_state == S_BUILD) && out_free);
    assign occ     = r_rem + r_wr;
    always_comb begin
        pop       = 1'b0;
        push      = 1'b0;
        push_data = s_rng;
        widx      = '0;
        if (r_state == S_COUNT) begin
            pop       = s_cons;
            push      = s_cons;
            push_data = head;
            widx      = r_n - CW'(1);
        end else if (r_state == S_BUILD && out_free) begin
            pop  = s_cons;
            push = s_emit;
            widx = occ - CW'(s_cons);
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_RANGES; k++) begin : g_cell
            t_range nxt;
            if (k == MAX_RANGES - 1) begin : g_end
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = chain[k+1];
            end
            mirs_cell u_cell (
                .i_clk     (i_clk),
                .i_pop     (pop),
                .i_wr      (push && (widx[IW-1:0] == IW'(k))),
                .i_wr_data (push_data),
                .i_next    (nxt),
                .o_data    (chain[k])
            );
        end
    endgenerate

    assign o_ready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_rem     = r_rem;
        n_wr      = r_wr;
        n_ecnt    = r_ecnt;
        n_m       = r_m;
        n_rep     = r_rep;
        ld        = 1'b0;
        ld_status = ST_OK;
        ld_rng    = s_rng;
        ld_empty  = 1'b0;
        ld_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_from_id > i_to_id || i_net_type != GSM_NET) begin
                        n_state = S_REPORT;
                        n_rep   = ST_INVALID;
                    end else begin
                        n_state = S_COUNT;
                        n_rem   = r_n;
                        n_m     = '0;
                    end
                end
            end
            S_COUNT: begin
                if (s_cons) n_rem = r_rem - CW'(1);
                if (s_emit && r_m <= MW'(MAX_RANGES)) n_m = r_m + MW'(1);
                if (s_fin) begin
                    if (r_m > MW'(MAX_RANGES)) begin
                        n_state = S_REPORT;
                        n_rep   = ST_FULL;
                    end else begin
                        n_state = S_BUILD;
                        n_rem   = r_n;
                        n_wr    = '0;
                        n_ecnt  = '0;
                    end
                end
            end
            S_BUILD: begin
                if (out_free) begin
                    if (s_cons) n_rem = r_rem - CW'(1);
                    if (s_emit) begin
                        ld      = 1'b1;
                        ld_last = (MW'(r_ecnt) + MW'(1) == r_m);
                        n_ecnt  = r_ecnt + CW'(1);
                        n_wr    = r_wr + CW'(1);
                    end
                    if (s_fin) begin
                        n_n     = r_m[CW-1:0];
                        n_state = (r_m == '0) ? S_EMPTY : S_IDLE;
                    end
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_status = r_rep;
                    ld_rng    = '0;
                    n_state   = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_rng   = '0;
                    ld_empty = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= '0;
            r_rem     <= '0;
            r_wr      <= '0;
            r_ecnt    <= '0;
            r_m       <= '0;
            r_ph      <= PH_BEFORE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_rem   <= n_rem;
            r_wr    <= n_wr;
            r_ecnt  <= n_ecnt;
            r_m     <= n_m;
            if (r_state == S_COUNT && s_fin) begin
                r_ph <= PH_BEFORE;
            end else if (r_state == S_IDLE) begin
                r_ph <= PH_BEFORE;
            end else if (step_en) begin
                r_ph <= n_ph;
            end
            if (ld) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold request arguments, accumulator and result payload
    always_ff @(posedge i_clk) begin
        r_rep <= n_rep;
        if (r_state == S_IDLE && i_valid) begin
            r_op <= i_opcode;
            r_a  <= i_from_id;
            r_b  <= i_to_id;
        end
        if (step_en) begin
            r_acc_lo <= n_acc_lo;
            r_acc_hi <= n_acc_hi;
        end
        if (ld) begin
            r_o_status <= ld_status;
            r_o_lo     <= ld_rng.lo;
            r_o_hi     <= ld_rng.hi;
            r_o_empty  <= ld_empty;
            r_o_last   <= ld_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_range_lo = r_o_lo;
    assign o_range_hi = r_o_hi;
    assign o_is_empty = r_o_empty;
    assign o_last     = r_o_last;
endmodule
`default_nettype wire

>>> src/mirs_cell.sv
// One table cell of the range chain: holds one range, shifts from its neighbor.
// Depends on mirs_pkg.
`default_nettype none
module mirs_cell (
    input  wire              i_clk,
    input  wire              i_pop,
    input  wire              i_wr,
    input  mirs_pkg::t_range i_wr_data,
    input  mirs_pkg::t_range i_next,
    output mirs_pkg::t_range o_data
);
    import mirs_pkg::*;

    t_range r_data;

    // Take the pushed range, else advance the neighbor's range on a pop
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_data <= i_wr_data;
        end else if (i_pop) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;
endmodule
`default_nettype wire

>>> sim/message_id_range_set_tb.sv
// Testbench for message_id_range_set: random and directed range commands, predicted table check.
// Depends on mirs_pkg and the message_id_range_set RTL.
`default_nettype none
module message_id_range_set_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mirs_pkg::*;

    typedef struct packed {
        logic        opcode;
        logic [15:0] from_id;
        logic [15:0] to_id;
        logic [7:0]  net_type;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] range_lo;
        logic [15:0] range_hi;
        logic        is_empty;
        logic        last;
    } t_table_row;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_opcode = 1'b0;
    logic [15:0] req_from = '0;
    logic [15:0] req_to = '0;
    logic [7:0]  req_net = '0;
    logic        req_ready;
    logic        row_valid;
    logic        row_ready = 1'b0;
    t_status     row_status;
    logic [15:0] row_lo, row_hi;
    logic        row_empty, row_last;

    t_request   pending_q[$];
    t_table_row expected_rows[$];
    int         failures = 0;
    int         cycles = 0;
    bit         stim_done = 0;

    // Predicted table
    int tbl_lo[MAX_RANGES];
    int tbl_hi[MAX_RANGES];
    int tbl_n = 0;

    message_id_range_set DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_opcode(req_opcode), .i_from_id(req_from), .i_to_id(req_to),
        .i_net_type(req_net),
        .o_valid(row_valid), .i_ready(row_ready),
        .o_status(row_status), .o_range_lo(row_lo), .o_range_hi(row_hi),
        .o_is_empty(row_empty), .o_last(row_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_table_row make_row(t_status s, int lo, int hi, bit e, bit l);
        t_table_row r;
        r.status = s;
        r.range_lo = lo[15:0];
        r.range_hi = hi[15:0];
        r.is_empty = e;
        r.last = l;
        return r;
    endfunction

    // Append one expected row
    function automatic void queue_row(t_table_row r);
        expected_rows.insert(expected_rows.size(), r);
    endfunction

    // Apply one request to the predicted table and queue the rows it yields
    task automatic predict_table(t_request rq);
        int nlo[$], nhi[$];
        int a, b, i, lo, hi;
        a = rq.from_id;
        b = rq.to_id;
        if (a > b || rq.net_type != GSM_NET) begin
            queue_row(make_row(ST_INVALID, 0, 0, 0, 1));
            return;
        end
        if (rq.opcode) begin
            i = 0;
            lo = a;
            hi = b;
            while (i < tbl_n && tbl_hi[i] + 1 < a) begin
                nlo.insert(nlo.size(), tbl_lo[i]); nhi.insert(nhi.size(), tbl_hi[i]); i++;
            end
            while (i < tbl_n && tbl_lo[i] <= b + 1) begin
                if (tbl_lo[i] < lo) lo = tbl_lo[i];
                if (tbl_hi[i] > hi) hi = tbl_hi[i];
                i++;
            end
            nlo.insert(nlo.size(), lo); nhi.insert(nhi.size(), hi);
            while (i < tbl_n) begin
                nlo.insert(nlo.size(), tbl_lo[i]); nhi.insert(nhi.size(), tbl_hi[i]); i++;
            end
        end else begin
            for (i = 0; i < tbl_n; i++) begin
                if (tbl_hi[i] < a || tbl_lo[i] > b) begin
                    nlo.insert(nlo.size(), tbl_lo[i]); nhi.insert(nhi.size(), tbl_hi[i]);
                end else begin
                    if (tbl_lo[i] < a) begin
                        nlo.insert(nlo.size(), tbl_lo[i]); nhi.insert(nhi.size(), a - 1);
                    end
                    if (tbl_hi[i] > b) begin
                        nlo.insert(nlo.size(), b + 1); nhi.insert(nhi.size(), tbl_hi[i]);
                    end
                end
            end
        end
        if (nlo.size() > MAX_RANGES) begin
            queue_row(make_row(ST_FULL, 0, 0, 0, 1));
            return;
        end
        tbl_n = nlo.size();
        for (i = 0; i < tbl_n; i++) begin
            tbl_lo[i] = nlo[i];
            tbl_hi[i] = nhi[i];
        end
        if (tbl_n == 0) queue_row(make_row(ST_OK, 0, 0, 1, 1));
        for (i = 0; i < tbl_n; i++)
            queue_row(make_row(ST_OK, tbl_lo[i], tbl_hi[i], 0, i == tbl_n - 1));
    endtask

    function automatic t_request mk(bit op, int f, int t, int net);
        t_request r;
        r.opcode = op;
        r.from_id = f[15:0];
        r.to_id = t[15:0];
        r.net_type = net[7:0];
        return r;
    endfunction

    // Append one pending request
    function automatic void queue_request(t_request r);
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && req_ready) begin
                predict_table(mk(req_opcode, req_from, req_to, req_net));
            end
            if (!req_valid || req_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_request rq;
                    rq = pending_q[0];
                    pending_q.delete(0);
                    req_valid <= 1'b1;
                    req_opcode <= rq.opcode;
                    req_from <= rq.from_id;
                    req_to <= rq.to_id;
                    req_net <= rq.net_type;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 6);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: receiver stalls on its own pattern, compare rows
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n) begin
            row_ready <= (cycles % 256 < 96) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (row_valid && row_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("unexpected row: status %0d lo %0h hi %0h", row_status, row_lo, row_hi);
                    failures <= failures + 1;
                end else begin
                    t_table_row e;
                    int bad;
                    e = expected_rows[0];
                    expected_rows.delete(0);
                    bad = 0;
                    if (row_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, row_status); bad++;
                    end
                    if (row_lo !== e.range_lo) begin
                        $error("range_lo expected %0h actual %0h", e.range_lo, row_lo); bad++;
                    end
                    if (row_hi !== e.range_hi) begin
                        $error("range_hi expected %0h actual %0h", e.range_hi, row_hi); bad++;
                    end
                    if (row_empty !== e.is_empty) begin
                        $error("is_empty expected %0b actual %0b", e.is_empty, row_empty); bad++;
                    end
                    if (row_last !== e.last) begin
                        $error("last expected %0b actual %0b", e.last, row_last); bad++;
                    end
                    failures <= failures + bad;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("message_id_range_set_tb: FAIL");
            $finish;
        end
    end

    // Fill the request queue: directed part, then random part
    initial begin
        int k, base, w, net;
        queue_request(mk(1, 0, 0, 1));
        queue_request(mk(1, 65535, 65535, 1));
        queue_request(mk(1, 1, 65534, 1));
        queue_request(mk(0, 0, 65535, 1));
        queue_request(mk(0, 5, 9, 1));
        queue_request(mk(1, 10, 20, 1));
        queue_request(mk(1, 21, 30, 1));
        queue_request(mk(1, 5, 9, 1));
        queue_request(mk(1, 12, 15, 1));
        queue_request(mk(0, 12, 15, 1));
        queue_request(mk(0, 0, 65535, 1));
        queue_request(mk(1, 9, 8, 1));
        queue_request(mk(1, 3, 4, 0));
        queue_request(mk(0, 3, 4, 255));
        queue_request(mk(0, 65535, 0, 170));
        for (k = 0; k < 17; k++) queue_request(mk(1, 4 * k, 4 * k + 1, 1));
        queue_request(mk(0, 1, 1, 1));
        queue_request(mk(0, 0, 65535, 1));
        // Random: mostly valid commands on a few scales, some noise
        for (k = 0; k < 324; k++) begin
            net = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : 1;
            case ($urandom_range(0, 3))
                0: begin
                    base = $urandom_range(0, 200);
                    w = $urandom_range(0, 8);
                end
                1: begin
                    base = $urandom_range(0, 65535);
                    w = $urandom_range(0, 65535 - base);
                end
                2: begin
                    base = $urandom_range(0, 65535);
                    w = $urandom_range(0, 3);
                    if (base + w > 65535) w = 65535 - base;
                end
                default: begin
                    base = $urandom_range(0, 65535);
                    w = -$urandom_range(1, 100);
                end
            endcase
            if (base + w < 0) w = -base;
            queue_request(mk($urandom_range(0, 2) != 0, base, base + w, net));
            if (k % 120 == 119) queue_request(mk(0, 0, 65535, 1));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !req_valid && expected_rows.size() == 0);
        repeat (100) @(posedge clk);
        if (failures == 0 && expected_rows.size() == 0) begin
            $display("message_id_range_set_tb: PASS");
        end else begin
            $display("message_id_range_set_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
